### rtl/abdown_pkg.sv
// Shared types and constants for the alpha box-average downscaler.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package abdown_pkg;

   localparam int TGT_W   = 64;
   localparam int TGT_H   = 64;
   localparam int MAX_DIM = 4096;

   localparam int DIM_W   = $clog2(MAX_DIM) + 1;
   localparam int POS_W   = $clog2(MAX_DIM);
   localparam int COL_W   = $clog2(TGT_W);
   localparam int ROW_W   = $clog2(TGT_H);
   localparam int ALPHA_W = 8;
   localparam int GRAY_W  = 8;
   localparam int BINX_W  = $clog2(MAX_DIM / TGT_W + 2);
   localparam int BINY_W  = $clog2(MAX_DIM / TGT_H + 2);
   localparam int AREA_W  = BINX_W + BINY_W;
   localparam int SUM_W   = ALPHA_W + AREA_W;
   localparam int STEP_W  = $clog2(ALPHA_W);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;

   localparam logic [DIM_W-1:0]  RESET_WIDTH  = DIM_W'(512);
   localparam logic [DIM_W-1:0]  RESET_HEIGHT = DIM_W'(512);
   localparam logic [GRAY_W-1:0] RESET_GRAY   = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_GRAY   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_HOLD
   } div_state_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } dims_type;

   typedef struct packed {
      logic [COL_W-1:0]   col;
      logic [ALPHA_W-1:0] alpha;
      logic               emit;
      logic               last;
      logic [BINX_W-1:0]  binx;
      logic [BINY_W-1:0]  biny;
   } item_type;

   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [AREA_W-1:0] area;
      logic              last;
   } div_req_type;

endpackage

### rtl/abdown_scan.sv
// Source position and bin boundary tracking for the downscaler.
// Depends on abdown_pkg; feeds abdown_accum with one item descriptor per pixel.
`timescale 1ns / 1ps

module abdown_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          restart,
   input  abdown_pkg::dims_type          dims,
   input  abdown_pkg::dims_type          dims_in,
   input  logic [abdown_pkg::ALPHA_W-1:0] alpha,
   output abdown_pkg::item_type          item
);
   import abdown_pkg::*;

   logic [POS_W-1:0] src_col_ff, src_col_in;
   logic [POS_W-1:0] src_row_ff, src_row_in;
   logic [COL_W-1:0] tcol_ff, tcol_in;
   logic [ROW_W-1:0] trow_ff, trow_in;
   logic [DIM_W-1:0] col_end_ff, col_end_in;
   logic [DIM_W-1:0] row_end_ff, row_end_in;
   logic [DIM_W-1:0] col_start_ff, col_start_in;
   logic [DIM_W-1:0] row_start_ff, row_start_in;

   logic [DIM_W-1:0] col_inc, row_inc;
   logic end_col, end_band, end_row, end_image;
   logic [COL_W+DIM_W:0] col_prod;
   logic [ROW_W+DIM_W:0] row_prod;
   logic [DIM_W-1:0] col_edge, row_edge;
   logic col_more, row_more;

   always_comb begin
      col_inc   = DIM_W'(src_col_ff) + DIM_W'(1);
      row_inc   = DIM_W'(src_row_ff) + DIM_W'(1);
      end_col   = (col_inc == col_end_ff);
      end_band  = (row_inc == row_end_ff);
      end_row   = (col_inc >= dims.width);
      end_image = end_row && (row_inc >= dims.height);
      col_more  = ({1'b0, tcol_ff} + (COL_W+1)'(1)) < (COL_W+1)'(TGT_W);
      row_more  = ({1'b0, trow_ff} + (ROW_W+1)'(1)) < (ROW_W+1)'(TGT_H);
      col_prod  = (COL_W+DIM_W+1)'({1'b0, tcol_ff} + (COL_W+1)'(2))
                  * (COL_W+DIM_W+1)'(dims.width);
      row_prod  = (ROW_W+DIM_W+1)'({1'b0, trow_ff} + (ROW_W+1)'(2))
                  * (ROW_W+DIM_W+1)'(dims.height);
      col_edge  = DIM_W'(col_prod / TGT_W);
      row_edge  = DIM_W'(row_prod / TGT_H);
   end

   always_comb begin
      item.col   = tcol_ff;
      item.alpha = alpha;
      item.emit  = end_col && end_band;
      item.last  = end_image;
      item.binx  = BINX_W'(col_end_ff - col_start_ff);
      item.biny  = BINY_W'(row_end_ff - row_start_ff);
   end

   always_comb begin
      src_col_in   = src_col_ff;
      src_row_in   = src_row_ff;
      tcol_in      = tcol_ff;
      trow_in      = trow_ff;
      col_end_in   = col_end_ff;
      row_end_in   = row_end_ff;
      col_start_in = col_start_ff;
      row_start_in = row_start_ff;
      if (restart) begin
         src_col_in   = '0;
         src_row_in   = '0;
         tcol_in      = '0;
         trow_in      = '0;
         col_start_in = '0;
         row_start_in = '0;
         col_end_in   = DIM_W'(dims_in.width / TGT_W);
         row_end_in   = DIM_W'(dims_in.height / TGT_H);
      end else if (accept) begin
         if (end_row) begin
            src_col_in   = '0;
            tcol_in      = '0;
            col_start_in = '0;
            col_end_in   = DIM_W'(dims.width / TGT_W);
            if (end_image) begin
               src_row_in   = '0;
               trow_in      = '0;
               row_start_in = '0;
               row_end_in   = DIM_W'(dims.height / TGT_H);
            end else begin
               src_row_in = src_row_ff + POS_W'(1);
               if (end_band && row_more) begin
                  trow_in      = trow_ff + ROW_W'(1);
                  row_start_in = row_end_ff;
                  row_end_in   = row_edge;
               end
            end
         end else begin
            src_col_in = src_col_ff + POS_W'(1);
            if (end_col && col_more) begin
               tcol_in      = tcol_ff + COL_W'(1);
               col_start_in = col_end_ff;
               col_end_in   = col_edge;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         tcol_ff      <= '0;
         trow_ff      <= '0;
         col_start_ff <= '0;
         row_start_ff <= '0;
         col_end_ff   <= DIM_W'(RESET_WIDTH / TGT_W);
         row_end_ff   <= DIM_W'(RESET_HEIGHT / TGT_H);
      end else begin
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         tcol_ff      <= tcol_in;
         trow_ff      <= trow_in;
         col_start_ff <= col_start_in;
         row_start_ff <= row_start_in;
         col_end_ff   <= col_end_in;
         row_end_ff   <= row_end_in;
      end
   end

endmodule

### rtl/abdown_accum.sv
// Per-column sum memory with read-modify-write and write forwarding.
// Depends on abdown_pkg; takes items from abdown_scan, launches abdown_divider.
`timescale 1ns / 1ps

module abdown_accum (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      restart,
   input  logic                      accept,
   input  abdown_pkg::item_type      item,
   input  logic                      div_ready,
   output logic                      ready,
   output logic                      launch_valid,
   output abdown_pkg::div_req_type   launch
);
   import abdown_pkg::*;

   logic [SUM_W-1:0] sum_mem [TGT_W];

   logic [TGT_W-1:0] entry_vld_ff, entry_vld_in;
   logic             s1_vld_ff, s1_vld_in;
   item_type         s1_item_ff;
   logic [SUM_W-1:0] rd_data_ff;
   logic             rd_vld_ff;
   logic             fwd_ff;
   logic [SUM_W-1:0] fwd_data_ff;

   logic [SUM_W-1:0] cur_sum, new_sum, wr_data;
   logic             s1_done;

   always_comb begin
      if (fwd_ff) begin
         cur_sum = fwd_data_ff;
      end else if (rd_vld_ff) begin
         cur_sum = rd_data_ff;
      end else begin
         cur_sum = '0;
      end
      new_sum  = cur_sum + SUM_W'(s1_item_ff.alpha);
      s1_done  = s1_vld_ff && (!s1_item_ff.emit || div_ready);
      wr_data  = s1_item_ff.emit ? '0 : new_sum;
      ready    = !s1_vld_ff || s1_done;

      launch_valid = s1_vld_ff && s1_item_ff.emit;
      launch.sum   = new_sum;
      launch.area  = AREA_W'(s1_item_ff.binx) * AREA_W'(s1_item_ff.biny);
      launch.last  = s1_item_ff.last;
   end

   always_comb begin
      entry_vld_in = entry_vld_ff;
      if (restart) begin
         entry_vld_in = '0;
      end else if (s1_done) begin
         entry_vld_in[s1_item_ff.col] = 1'b1;
      end
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_done) begin
         s1_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_done) begin
         sum_mem[s1_item_ff.col] <= wr_data;
      end
      if (accept) begin
         rd_data_ff <= sum_mem[item.col];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
         s1_vld_ff    <= 1'b0;
      end else begin
         entry_vld_ff <= entry_vld_in;
         s1_vld_ff    <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff  <= item;
         rd_vld_ff   <= entry_vld_ff[item.col];
         fwd_ff      <= s1_done && (s1_item_ff.col == item.col);
         fwd_data_ff <= wr_data;
      end
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s1_done |=> s1_vld_ff && $stable(s1_item_ff))
      else $error("stalled sum stage lost its item");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      restart |=> entry_vld_ff == '0)
      else $error("column sums not cleared on restart");

endmodule

### rtl/abdown_divider.sv
// Iterative restoring divider producing the bin average, plus the result register.
// Depends on abdown_pkg; launched by abdown_accum, drives the rsp_ channel.
`timescale 1ns / 1ps

module abdown_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           launch_valid,
   input  abdown_pkg::div_req_type        launch,
   input  logic [abdown_pkg::GRAY_W-1:0]  gray,
   output logic                           div_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [abdown_pkg::GRAY_W-1:0]  rsp_gray,
   output logic [abdown_pkg::ALPHA_W-1:0] rsp_alpha,
   output logic                           rsp_last
);
   import abdown_pkg::*;

   div_state_type     state_ff, state_in;
   logic [SUM_W-1:0]  rem_ff;
   logic [AREA_W-1:0] den_ff;
   logic [ALPHA_W-1:0] quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic              last_ff;
   logic [GRAY_W-1:0] gray_ff;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [GRAY_W-1:0] rsp_gray_ff;
   logic [ALPHA_W-1:0] rsp_alpha_ff;
   logic              rsp_last_ff;

   logic [SUM_W-1:0]  shifted;
   logic              fits;
   logic              take, running, load_out;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (launch_valid) begin
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (step_ff == '0) begin
               state_in = DIV_HOLD;
            end
         end
         DIV_HOLD: begin
            if (!rsp_vld_ff || rsp_ready) begin
               state_in = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_comb begin
      div_ready = 1'b0;
      running   = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         DIV_IDLE: div_ready = 1'b1;
         DIV_RUN:  running   = 1'b1;
         DIV_HOLD: load_out  = !rsp_vld_ff || rsp_ready;
         default: ;
      endcase
      take = div_ready && launch_valid;
   end

   always_comb begin
      shifted = SUM_W'(den_ff) << step_ff;
      fits    = rem_ff >= shifted;
      rsp_vld_in = rsp_vld_ff;
      if (load_out) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= DIV_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rem_ff  <= launch.sum;
         den_ff  <= launch.area;
         quo_ff  <= '0;
         step_ff <= STEP_W'(ALPHA_W - 1);
         last_ff <= launch.last;
         gray_ff <= gray;
      end else if (running) begin
         if (fits) begin
            rem_ff <= rem_ff - shifted;
         end
         quo_ff  <= {quo_ff[ALPHA_W-2:0], fits};
         step_ff <= step_ff - STEP_W'(1);
      end
      if (load_out) begin
         rsp_gray_ff  <= gray_ff;
         rsp_alpha_ff <= quo_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_gray  = rsp_gray_ff;
   assign rsp_alpha = rsp_alpha_ff;
   assign rsp_last  = rsp_last_ff;

   a_step_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == DIV_RUN && step_ff != '0
      |=> state_ff == DIV_RUN && step_ff == $past(step_ff) - STEP_W'(1))
      else $error("divider step count skipped");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == DIV_HOLD |-> rem_ff < SUM_W'(den_ff))
      else $error("average exceeds quotient width");

endmodule

### rtl/alpha_box_average_downscaler_unit.sv
// Top level of the alpha box-average downscaler.
// Depends on abdown_pkg, abdown_scan, abdown_accum and abdown_divider.
//
// Usage: source alpha bytes enter in raster order on req_ (valid/ready), one
// item per accepted handshake. A 64x64 target pixel leaves on rsp_ when the
// last source pixel of its bin has been taken: gray level, floor-average
// alpha, and last_pixel set on the final pixel of the image.
// Throughput: one item per cycle for pixels that do not close a bin. A pixel
// that closes a bin goes to an 8-step restoring divider that stays busy from
// taking the item until its result is loaded into the result register; a
// second bin-closing pixel arriving meanwhile holds req_ready low until the
// divider is free.
// A result reaches rsp_valid through one read-modify-write stage on the column
// sum memory, the 8 divide steps and the hold state into the result register.
// Reset: source size 512x512, gray 0, all 64 column sums marked empty; no
// clearing pass. A write of width or height restarts the image the same way.
// When rsp_ready is low the result register holds; the divider then waits and
// bin-closing items back up into req_ready.
`timescale 1ns / 1ps

module alpha_box_average_downscaler_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [abdown_pkg::ALPHA_W-1:0]    req_source_alpha,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [abdown_pkg::GRAY_W-1:0]     rsp_pixel_gray,
   output logic [abdown_pkg::ALPHA_W-1:0]    rsp_pixel_alpha,
   output logic                              rsp_last_pixel,
   input  logic                              csr_we,
   input  logic [abdown_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [abdown_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import abdown_pkg::*;

   dims_type          dims_ff, dims_in;
   logic [GRAY_W-1:0] gray_ff, gray_in;
   logic              restart;
   logic              accept;
   item_type          item;
   logic              div_ready;
   logic              launch_valid;
   div_req_type       launch;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v,
                                                  input logic [DIM_W-1:0] lo);
      logic [DIM_W-1:0] r;
      r = DIM_W'(v);
      if (r < lo) begin
         r = lo;
      end else if (r > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   always_comb begin
      dims_in = dims_ff;
      gray_in = gray_ff;
      restart = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_WIDTH: begin
               dims_in.width = clamp_dim(csr_wdata, DIM_W'(TGT_W));
               restart       = 1'b1;
            end
            CSR_HEIGHT: begin
               dims_in.height = clamp_dim(csr_wdata, DIM_W'(TGT_H));
               restart        = 1'b1;
            end
            CSR_GRAY: gray_in = GRAY_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.width  <= RESET_WIDTH;
         dims_ff.height <= RESET_HEIGHT;
         gray_ff        <= RESET_GRAY;
      end else begin
         dims_ff <= dims_in;
         gray_ff <= gray_in;
      end
   end

   assign accept = req_valid && req_ready;

   abdown_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .restart (restart),
      .dims    (dims_ff),
      .dims_in (dims_in),
      .alpha   (req_source_alpha),
      .item    (item)
   );

   abdown_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .accept       (accept),
      .item         (item),
      .div_ready    (div_ready),
      .ready        (req_ready),
      .launch_valid (launch_valid),
      .launch       (launch)
   );

   abdown_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .launch_valid (launch_valid),
      .launch       (launch),
      .gray         (gray_ff),
      .div_ready    (div_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_gray     (rsp_pixel_gray),
      .rsp_alpha    (rsp_pixel_alpha),
      .rsp_last     (rsp_last_pixel)
   );

endmodule

### bench/testbench.sv
// Testbench for alpha_box_average_downscaler_unit: streams alpha items under varied
// sizes, gray levels and pacing, predicts each 64x64 box average and checks every result.
// Depends on abdown_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
   import abdown_pkg::*;

   localparam int CLOCK_PERIOD   = 4;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int SETTLE_CYCLES  = 30;
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_ITEMS   = 600;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct {
      logic [GRAY_W-1:0]  gray;
      logic [ALPHA_W-1:0] alpha;
      logic               last_flag;
   } downscaled_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [ALPHA_W-1:0]    req_source_alpha = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [GRAY_W-1:0]     rsp_pixel_gray;
   logic [ALPHA_W-1:0]    rsp_pixel_alpha;
   logic                  rsp_last_pixel;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic                  req_fire = 1'b0;
   logic [ALPHA_W-1:0]    pending_alpha[$];
   downscaled_pixel_type  expected_pixels[$];
   downscaled_pixel_type  oldest_pixel;
   int unsigned           pixels_queued = 0;
   int unsigned           pixels_accepted = 0;
   int unsigned           mismatch_count = 0;
   int unsigned           send_idle_pct = 0;
   int unsigned           recv_stall_pct = 0;
   int unsigned           phase_count = 0;
   int unsigned           random_items = 0;

   // shadow of the block's registers and image position
   logic [DIM_W-1:0]      width_reg = RESET_WIDTH;
   logic [DIM_W-1:0]      height_reg = RESET_HEIGHT;
   logic [GRAY_W-1:0]     gray_reg = RESET_GRAY;
   int unsigned           src_col, src_row, bin_col, bin_row, col_limit, row_limit;
   int unsigned           band_sums[TGT_W];

   alpha_box_average_downscaler_unit dut (.*);

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw,
                                             input int unsigned tgt);
      if (raw < tgt) return tgt;
      if (raw > MAX_DIM) return MAX_DIM;
      return raw;
   endfunction

   function automatic int unsigned bin_bound(input int unsigned i, input int unsigned dim,
                                             input int unsigned tgt);
      return (i * dim) / tgt;
   endfunction

   function void restart_image();
      int unsigned w, h;
      w = clamp_dim(width_reg, TGT_W);
      h = clamp_dim(height_reg, TGT_H);
      src_col = 0;
      src_row = 0;
      bin_col = 0;
      bin_row = 0;
      col_limit = bin_bound(1, w, TGT_W);
      row_limit = bin_bound(1, h, TGT_H);
      foreach (band_sums[i]) band_sums[i] = 0;
   endfunction

   function void apply_register(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      case (idx)
         CSR_WIDTH: begin
            width_reg = value[DIM_W-1:0];
            restart_image();
         end
         CSR_HEIGHT: begin
            height_reg = value[DIM_W-1:0];
            restart_image();
         end
         CSR_GRAY: gray_reg = value[GRAY_W-1:0];
         default: ;
      endcase
   endfunction

   function void predict_downscale(input logic [ALPHA_W-1:0] alpha);
      int unsigned          w, h, area;
      bit                   col_done, band_done, row_done, image_done;
      downscaled_pixel_type px;
      w = clamp_dim(width_reg, TGT_W);
      h = clamp_dim(height_reg, TGT_H);
      band_sums[bin_col] += alpha;
      col_done = (src_col + 1 == col_limit);
      band_done = (src_row + 1 == row_limit);
      row_done = (src_col + 1 >= w);
      image_done = row_done && (src_row + 1 >= h);
      if (col_done && band_done) begin
         area = (col_limit - bin_bound(bin_col, w, TGT_W))
              * (row_limit - bin_bound(bin_row, h, TGT_H));
         px.gray = gray_reg;
         px.alpha = ALPHA_W'(band_sums[bin_col] / area);
         px.last_flag = image_done;
         expected_pixels.insert(expected_pixels.size(), px);
         band_sums[bin_col] = 0;
      end
      if (row_done) begin
         src_col = 0;
         bin_col = 0;
         col_limit = bin_bound(1, w, TGT_W);
         if (image_done) begin
            src_row = 0;
            bin_row = 0;
            row_limit = bin_bound(1, h, TGT_H);
         end else begin
            src_row++;
            if (band_done && bin_row + 1 < TGT_H) begin
               bin_row++;
               row_limit = bin_bound(bin_row + 1, h, TGT_H);
            end
         end
      end else begin
         src_col++;
         if (col_done && bin_col + 1 < TGT_W) begin
            bin_col++;
            col_limit = bin_bound(bin_col + 1, w, TGT_W);
         end
      end
   endfunction

   function automatic logic [ALPHA_W-1:0] random_alpha();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return ALPHA_W'($urandom_range(255));
      endcase
   endfunction

   function automatic int unsigned pick_dim();
      case ($urandom_range(19))
         0: return $urandom_range(63);
         1: return $urandom_range(8191, MAX_DIM + 1);
         2: return MAX_DIM;
         3: return $urandom_range(MAX_DIM - 1, 141);
         default: return $urandom_range(140, 64);
      endcase
   endfunction

   // drive side: hold the item until taken, then advance or idle
   always @(negedge clock) begin
      if (!req_valid || req_fire) begin
         if (pending_alpha.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_source_alpha <= pending_alpha.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected pixel: gray %0d alpha %0d last %0d",
                           rsp_pixel_gray, rsp_pixel_alpha, rsp_last_pixel);
            end else begin
               oldest_pixel = expected_pixels.pop_front();
               if (rsp_pixel_gray !== oldest_pixel.gray
                   || rsp_pixel_alpha !== oldest_pixel.alpha
                   || rsp_last_pixel !== oldest_pixel.last_flag) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("pixel mismatch: expected gray %0d alpha %0d last %0d,",
                              oldest_pixel.gray, oldest_pixel.alpha, oldest_pixel.last_flag,
                              " got gray %0d alpha %0d last %0d",
                              rsp_pixel_gray, rsp_pixel_alpha, rsp_last_pixel);
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_downscale(req_source_alpha);
            pixels_accepted++;
         end
      end
      req_fire <= !reset && req_valid && req_ready;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      apply_register(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic begin_phase();
      @(posedge clock);
      case (phase_count % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
         default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      phase_count++;
   endtask

   task automatic queue_pixel(input logic [ALPHA_W-1:0] alpha);
      pending_alpha.insert(pending_alpha.size(), alpha);
      pixels_queued++;
   endtask

   task automatic queue_pixels(input int unsigned count);
      @(posedge clock);
      repeat (count) queue_pixel(random_alpha());
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pixels_accepted != pixels_queued || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned count;
      restart_image();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset size: no bin closes this early
      begin_phase();
      queue_pixels(8);
      wait_drained();

      // one-pixel bins, saturated low sizes, full gray
      begin_phase();
      write_reg(CSR_WIDTH, 0);
      write_reg(CSR_HEIGHT, 63);
      write_reg(CSR_GRAY, 255);
      @(posedge clock);
      queue_pixel(8'd255);
      queue_pixel(8'd0);
      queue_pixel(8'd1);
      queue_pixel(8'd254);
      queue_pixel(8'd128);
      queue_pixel(8'd127);
      wait_drained();

      // spare index must not restart the image; gray changes mid image
      begin_phase();
      write_reg(CSR_SPARE_INDEX, 8191);
      write_reg(CSR_GRAY, 0);
      @(posedge clock);
      queue_pixel(8'd90);
      queue_pixel(8'd0);
      queue_pixel(8'd255);
      wait_drained();

      // saturated high sizes
      begin_phase();
      write_reg(CSR_WIDTH, 8191);
      write_reg(CSR_HEIGHT, MAX_DIM + 1);
      queue_pixels(10);
      wait_drained();

      // minimum size: every pixel closes its own bin, two full rows
      begin_phase();
      write_reg(CSR_WIDTH, TGT_W);
      write_reg(CSR_HEIGHT, TGT_H);
      write_reg(CSR_GRAY, $urandom_range(255));
      queue_pixels(2 * TGT_W);
      wait_drained();

      while (random_items < RANDOM_ITEMS) begin
         begin_phase();
         if ($urandom_range(3) != 0) write_reg(CSR_WIDTH, pick_dim());
         if ($urandom_range(3) != 0) write_reg(CSR_HEIGHT, pick_dim());
         write_reg(CSR_GRAY, $urandom_range(255));
         count = $urandom_range(200, 40);
         queue_pixels(count);
         random_items += count;
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("testbench NOT OK");
      $finish;
   end

endmodule

### files.f
rtl/abdown_pkg.sv
rtl/abdown_scan.sv
rtl/abdown_accum.sv
rtl/abdown_divider.sv
rtl/alpha_box_average_downscaler_unit.sv
bench/testbench.sv
